// ===== hdl/pfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths, codes, reset values and controller/datapath bundles for the
// paging frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Field widths fixed by the interface
  localparam int CAP_W    = 23;
  localparam int FSZ_W    = 17;
  localparam int FCNT_W   = 7;
  localparam int REQ_W    = 23;
  localparam int TID_W    = 16;
  localparam int STAT_W   = 2;
  localparam int ADDR_W   = 22;
  localparam int BYTES_W  = 23;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int NUM_FRAMES_DEF = 64;
  localparam int ID_BITS_DEF    = 16;

  // Saturation limit of the used-byte total
  localparam logic [BYTES_W-1:0] USED_MAX = {BYTES_W{1'b1}};

  // Configuration reset values
  localparam logic [CAP_W-1:0]  CAP_RST  = 23'd16384;
  localparam logic [FSZ_W-1:0]  FSZ_RST  = 17'd256;
  localparam logic [FCNT_W-1:0] FCNT_RST = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_FRAMES = 2'd2;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request beat
    logic check;   // size check, clear scan state
    logic scan;    // walk the owner table
    logic commit;  // update table, counters, result
    logic emit;    // hand the result to the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad_size;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/pfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer for one request at a time: check, table scan (skipped for a rejected size), commit, emit.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_free,
  input  wire pfa_pkg::dp_status_t  st,
  output pfa_pkg::dp_cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = st.bad_size ? ST_COMMIT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pfa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_datapath
// Owner table (valid flops plus id memory), scan pipeline, byte accumulators,
// id counter and used-byte total.
// ----------------------------------------------------------------------------
module pfa_datapath #(
  parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
  parameter int ID_BITS    = pfa_pkg::ID_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pfa_pkg::dp_cmd_t               cmd,
  output pfa_pkg::dp_status_t                 st,
  input  wire logic                           in_command,
  input  wire logic [pfa_pkg::REQ_W-1:0]      in_request_bytes,
  input  wire logic [pfa_pkg::TID_W-1:0]      in_target_id,
  input  wire logic [pfa_pkg::CAP_W-1:0]      capacity_bytes,
  input  wire logic [pfa_pkg::FSZ_W-1:0]      page_bytes,
  input  wire logic [pfa_pkg::FCNT_W-1:0]     frame_count,
  output logic [pfa_pkg::STAT_W-1:0]          res_status,
  output logic [pfa_pkg::TID_W-1:0]           res_id,
  output logic [pfa_pkg::ADDR_W-1:0]          res_start,
  output logic [pfa_pkg::BYTES_W-1:0]         res_used,
  output logic [pfa_pkg::BYTES_W-1:0]         res_free
);

  localparam int AW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int IDC = (ID_BITS > pfa_pkg::TID_W) ? ID_BITS : pfa_pkg::TID_W;
  localparam int FW  = pfa_pkg::CAP_W;        // effective frame size width
  localparam int AccW = FW + 1;               // byte accumulator width

  // request registers
  logic                          op;
  logic [pfa_pkg::REQ_W-1:0]     req;
  logic [pfa_pkg::TID_W-1:0]     tid;

  // persistent state
  logic [NUM_FRAMES-1:0]         valid;
  logic [ID_BITS-1:0]            mem [NUM_FRAMES];
  logic [ID_BITS-1:0]            id_counter;
  logic [pfa_pkg::BYTES_W-1:0]   used_total;

  // scan state
  logic [CW-1:0]                 idx;
  logic                          s1_vld;
  logic [AW-1:0]                 s1_idx;
  logic [ID_BITS-1:0]            rd_id;
  logic [NUM_FRAMES-1:0]         pending;
  logic [AccW-1:0]               acc;
  logic [pfa_pkg::ADDR_W-1:0]    addr;
  logic [pfa_pkg::ADDR_W-1:0]    first_addr;
  logic                          found;

  // combinational helpers
  logic [FW-1:0]                 fs;
  logic [CW-1:0]                 limit;
  logic [CW-1:0]                 scan_end;
  logic                          issue;
  logic [AccW:0]                 acc_sum;
  logic [AccW-1:0]               acc_add;
  logic                          hit;
  logic [AccW+1:0]               used_sum;
  logic [pfa_pkg::BYTES_W-1:0]   used_alloc;
  logic [pfa_pkg::BYTES_W-1:0]   used_freed;

  // a zero frame size acts as one frame of the whole capacity
  assign fs = (page_bytes == '0) ? capacity_bytes : FW'(page_bytes);

  always_comb begin
    if (32'(frame_count) > 32'(NUM_FRAMES)) begin
      limit = CW'(NUM_FRAMES);
    end else begin
      limit = CW'(frame_count);
    end
  end

  // allocate walks the usable frames, free walks the whole table
  assign scan_end = (op == pfa_pkg::CMD_FREE) ? CW'(NUM_FRAMES) : limit;
  assign issue    = cmd.scan && (idx != scan_end);

  assign st.bad_size  = (op == pfa_pkg::CMD_ALLOC) &&
                        ((req == '0) || (32'(req) > 32'(capacity_bytes)));
  assign st.scan_done = (idx == scan_end) && !s1_vld;

  // saturating byte accumulator
  assign acc_sum = {1'b0, acc} + (AccW + 1)'(fs);
  assign acc_add = acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];

  always_comb begin
    if (op == pfa_pkg::CMD_FREE) begin
      hit = valid[s1_idx] && (IDC'(rd_id) == IDC'(tid));
    end else begin
      hit = !valid[s1_idx] && (acc < AccW'(req));
    end
  end

  assign used_sum   = (AccW + 2)'(used_total) + (AccW + 2)'(acc);
  assign used_alloc = (used_sum > (AccW + 2)'(pfa_pkg::USED_MAX)) ? pfa_pkg::USED_MAX
                                                                 : used_sum[pfa_pkg::BYTES_W-1:0];
  assign used_freed = (acc >= AccW'(used_total)) ? '0
                                                 : used_total - acc[pfa_pkg::BYTES_W-1:0];

  assign res_used = used_total;
  assign res_free = (32'(used_total) >= 32'(capacity_bytes)) ? '0
                                                             : capacity_bytes - used_total;

  // id memory: read one entry ahead of stage 1, write claimed entries in stage 1
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_id <= mem[idx[AW-1:0]];
    end
    if (s1_vld && hit && (op == pfa_pkg::CMD_ALLOC)) begin
      mem[s1_idx] <= id_counter;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_command;
      req <= in_request_bytes;
      tid <= in_target_id;
    end
  end

  // scan pipeline and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      s1_vld <= 1'b0;
    end else if (cmd.check) begin
      idx    <= '0;
      s1_vld <= 1'b0;
    end else if (cmd.scan) begin
      s1_vld <= issue;
      if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx <= idx[AW-1:0];
    end
    if (cmd.check) begin
      pending    <= '0;
      acc        <= '0;
      addr       <= '0;
      first_addr <= '0;
      found      <= 1'b0;
    end else if (s1_vld) begin
      addr <= addr + fs[pfa_pkg::ADDR_W-1:0];
      if (hit) begin
        acc <= acc_add;
        if (!found) begin
          first_addr <= addr;
          found      <= 1'b1;
        end
        if (op == pfa_pkg::CMD_ALLOC) begin
          pending[s1_idx] <= 1'b1;
        end
      end
    end
  end

  // owner valid bits, id counter, used total, result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      id_counter <= '0;
      used_total <= '0;
    end else if (s1_vld && hit && (op == pfa_pkg::CMD_FREE)) begin
      valid[s1_idx] <= 1'b0;
    end else if (cmd.commit && !st.bad_size) begin
      if (op == pfa_pkg::CMD_ALLOC) begin
        if (acc >= AccW'(req)) begin
          valid      <= valid | pending;
          id_counter <= id_counter + 1'b1;
          used_total <= used_alloc;
        end
      end else if (found) begin
        used_total <= used_freed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status <= pfa_pkg::STAT_OK;
      res_id     <= tid;
      res_start  <= '0;
      if (st.bad_size) begin
        res_status <= pfa_pkg::STAT_BAD_SIZE;
      end else if (op == pfa_pkg::CMD_ALLOC) begin
        if (acc >= AccW'(req)) begin
          res_id    <= pfa_pkg::TID_W'(id_counter);
          res_start <= first_addr;
        end else begin
          res_status <= pfa_pkg::STAT_NO_FRAMES;
        end
      end else if (found) begin
        res_start <= first_addr;
      end else begin
        res_status <= pfa_pkg::STAT_UNKNOWN;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/paging_frame_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The owner table walk reads one entry a cycle through the id memory and covers
//   min(frame_count, NUM_FRAMES) entries for an allocate and NUM_FRAMES for a free; a
//   rejected size skips the walk.
// Throughput: one request at a time; the next beat is taken the cycle after the result
//   enters the output register.
// Reset: all frames free, id counter and used total zero, config 16384 / 256 / 64.
// ----------------------------------------------------------------------------
// paging_frame_allocator_core
// First-fit frame allocator with per-frame owner table, stream in/out ports
// and a plain configuration write port.
// ----------------------------------------------------------------------------
module paging_frame_allocator_core #(
  parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
  parameter int ID_BITS    = pfa_pkg::ID_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [39:0]                       s_tdata,  // request_bytes, target_id
  input  wire logic [0:0]                        s_tuser,  // command
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [87:0]                            m_tdata,  // given_id, start_address,
                                                           // used_bytes, free_bytes
  output logic [1:0]                             m_tuser,  // status
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pfa_pkg::CAP_W-1:0]         cfg_data
);

  pfa_pkg::dp_cmd_t    cmd;
  pfa_pkg::dp_status_t st;

  // configuration registers
  logic [pfa_pkg::CAP_W-1:0]   capacity_bytes;
  logic [pfa_pkg::FSZ_W-1:0]   page_bytes;
  logic [pfa_pkg::FCNT_W-1:0]  frame_count;

  // datapath result
  logic [pfa_pkg::STAT_W-1:0]  res_status;
  logic [pfa_pkg::TID_W-1:0]   res_id;
  logic [pfa_pkg::ADDR_W-1:0]  res_start;
  logic [pfa_pkg::BYTES_W-1:0] res_used;
  logic [pfa_pkg::BYTES_W-1:0] res_free;

  // output register
  logic [pfa_pkg::STAT_W-1:0]  out_status;
  logic [pfa_pkg::TID_W-1:0]   out_id;
  logic [pfa_pkg::ADDR_W-1:0]  out_start;
  logic [pfa_pkg::BYTES_W-1:0] out_used;
  logic [pfa_pkg::BYTES_W-1:0] out_free_bytes;
  logic                        out_free;

  // Take register writes at once; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bytes <= pfa_pkg::CAP_RST;
      page_bytes     <= pfa_pkg::FSZ_RST;
      frame_count    <= pfa_pkg::FCNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::CFG_CAPACITY:    capacity_bytes <= cfg_data;
        pfa_pkg::CFG_PAGE_BYTES:  page_bytes     <= cfg_data[pfa_pkg::FSZ_W-1:0];
        pfa_pkg::CFG_FRAME_COUNT: frame_count    <= cfg_data[pfa_pkg::FCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  pfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .in_command       (s_tuser[0]),
    .in_request_bytes (s_tdata[22:0]),
    .in_target_id     (s_tdata[38:23]),
    .capacity_bytes   (capacity_bytes),
    .page_bytes       (page_bytes),
    .frame_count      (frame_count),
    .res_status       (res_status),
    .res_id           (res_id),
    .res_start        (res_start),
    .res_used         (res_used),
    .res_free         (res_free)
  );

  // The output register parts the result side from the sequencer: a beat may
  // wait here while the next request is already being accepted.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the payload only on emit; hold it while stalled.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status     <= res_status;
      out_id         <= res_id;
      out_start      <= res_start;
      out_used       <= res_used;
      out_free_bytes <= res_free;
    end
  end

  assign m_tdata = {4'd0, out_free_bytes, out_used, out_start, out_id};
  assign m_tuser = out_status;

endmodule

`default_nettype wire
